FILE: rtl/zca_pkg.sv
// package for the zoned channel allocator: field widths, occupancy limits,
// default parameter values and the types shared by the top level and the occupancy unit
// no dependencies
package zca_pkg;

   localparam int CHANNELS_DEF  = 16;
   localparam int MAX_ZONES_DEF = 8;

   localparam int CHAN_W = 4;   // channel field width
   localparam int ZONE_W = 3;   // zone field width
   localparam int ZCNT_W = 4;   // zone_count register width
   localparam int OCC_W  = 8;   // occupancy width

   localparam logic signed [OCC_W-1:0] OCC_MAX = 8'sd127;
   localparam logic signed [OCC_W-1:0] OCC_MIN = -8'sd128;

   typedef logic signed [OCC_W-1:0] occ_type;

   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // status of one occupancy entry as seen by the scan sequencer
   typedef struct packed {
      logic below_min;   // entry is lower than the running minimum
      logic idle;        // entry is zero or below
   } zca_flags_type;

endpackage

FILE: rtl/zca_if.sv
// valid/ready channel interfaces for the zoned channel allocator
// depends on zca_pkg for field widths
interface zca_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [zca_pkg::ZONE_W-1:0] zone;
   logic [zca_pkg::CHAN_W-1:0] released_channel;

   modport source (output valid, output op, output zone, output released_channel,
                   input ready);
   modport sink (input valid, input op, input zone, input released_channel,
                 output ready);
endinterface

interface zca_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [zca_pkg::CHAN_W-1:0] channel;

   modport source (output valid, output channel, input ready);
   modport sink (input valid, input channel, output ready);
endinterface

interface zca_csr_if;
   logic                       valid;
   logic                       ready;
   logic [zca_pkg::ZCNT_W-1:0] zone_count;

   modport source (output valid, output zone_count, input ready);
   modport sink (input valid, input zone_count, output ready);
endinterface

FILE: rtl/zca_occ_alu.sv
// shared occupancy unit: compare against the running minimum and the
// saturating increment and decrement used by acquire and release; depends on zca_pkg
module zca_occ_alu (
   input  zca_pkg::occ_type       value,
   input  zca_pkg::occ_type       min_value,
   output zca_pkg::zca_flags_type flags,
   output zca_pkg::occ_type       inc_value,
   output zca_pkg::occ_type       dec_value
);
   import zca_pkg::*;

   assign flags.below_min = (value < min_value);
   assign flags.idle      = (value <= 8'sd0);

   // acquire: idle entries restart at one, busy ones count up to the top
   always_comb begin
      if (value <= 8'sd0) begin
         inc_value = 8'sd1;
      end else if (value < OCC_MAX) begin
         inc_value = value + 8'sd1;
      end else begin
         inc_value = OCC_MAX;
      end
   end

   assign dec_value = (value > OCC_MIN) ? (value - 8'sd1) : OCC_MIN;

endmodule

FILE: rtl/zoned_channel_allocator.sv
// Zoned channel allocator. The CHANNELS channels are split into zone_count zones
// (clamped to 1..min(MAX_ZONES, CHANNELS/2)); each zone is a master channel followed by its
// members, with leftover channels going one each to the first zones. An acquire scans the
// zone's members from its rotating pointer for the first least-occupied one; a release
// lowers the released channel if it is a member of the zone, and every idle member. Items
// are handled one at a time by a sequencer around a single occupancy compare/update unit
// that visits one member per cycle: an item passes through the zone and channel mod
// reduction, the layout step, the member scan and, for an acquire only, the update, then
// waits in the done state while the previous result word has not yet been taken. A
// zone_count write clears all occupancy and pointers and then recomputes the zone layout
// by repeated subtraction, during which no word is accepted. Depends on zca_pkg, the
// channel interfaces and zca_occ_alu.
module zoned_channel_allocator #(
   parameter int CHANNELS  = zca_pkg::CHANNELS_DEF,
   parameter int MAX_ZONES = zca_pkg::MAX_ZONES_DEF
) (
   input logic    clock,
   input logic    reset,
   zca_req_if.sink   req_chan,
   zca_rsp_if.source rsp_chan,
   zca_csr_if.sink   csr_chan
);
   import zca_pkg::*;

   localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ZONE_IDX_W = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
   localparam int ZONE_LIM_I = (MAX_ZONES < CHANNELS / 2) ? MAX_ZONES : CHANNELS / 2;
   localparam int ZONE_LIM   = (ZONE_LIM_I < 1) ? 1 : ZONE_LIM_I;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_DIV      = 8'b0000_0010,
      ST_MOD      = 8'b0000_0100,
      ST_LAYOUT   = 8'b0000_1000,
      ST_ACQ_SCAN = 8'b0001_0000,
      ST_ACQ_UPD  = 8'b0010_0000,
      ST_REL_SCAN = 8'b0100_0000,
      ST_DONE     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   occ_type              occ_ff [CHANNELS];
   occ_type              occ_in [CHANNELS];
   logic [CHAN_W-1:0]    ss_ff  [MAX_ZONES];
   logic [CHAN_W-1:0]    ss_in  [MAX_ZONES];

   logic [ZCNT_W-1:0]    zones_ff, zones_in;
   logic [CHAN_W-1:0]    base_ff, base_in;      // members per zone before the remainder
   logic [ZONE_W-1:0]    rem_ff, rem_in;
   logic [CHAN_W:0]      div_r_ff, div_r_in;
   logic [CHAN_W:0]      div_q_ff, div_q_in;

   logic                 op_ff, op_in;
   logic [ZONE_W-1:0]    k_ff, k_in;
   logic [CHAN_W-1:0]    ch_ff, ch_in;
   logic [CHAN_W-1:0]    first_ff, first_in;
   logic [CHAN_W-1:0]    span_ff, span_in;
   logic [CHAN_W-1:0]    off_ff, off_in;
   logic [CHAN_W-1:0]    cnt_ff, cnt_in;
   logic [CHAN_W-1:0]    pos_ff, pos_in;
   occ_type              minv_ff, minv_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]    rsp_channel_ff, rsp_channel_in;

   logic                 req_fire, csr_fire;
   logic [ZCNT_W-1:0]    zones_new;
   logic [ZONE_IDX_W-1:0] zone_sel;
   logic [CHAN_W-1:0]    scan_ch;
   logic [CHAN_W-1:0]    acq_ch;
   occ_type              alu_value;
   zca_flags_type        alu_flags;
   occ_type              alu_inc, alu_dec;
   logic [7:0]           master_prod;
   logic [ZONE_W-1:0]    k_min_rem;
   logic                 k_lt_rem;
   logic                 k_reduce, ch_reduce;
   logic                 off_wrap;

   assign csr_chan.ready = (state_ff == ST_IDLE);
   assign req_chan.ready = (state_ff == ST_IDLE) && !csr_chan.valid;
   assign csr_fire       = csr_chan.valid && csr_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.channel = rsp_channel_ff;

   always_comb begin
      if (csr_chan.zone_count == '0) begin
         zones_new = ZCNT_W'(1);
      end else if (csr_chan.zone_count > ZCNT_W'(ZONE_LIM)) begin
         zones_new = ZCNT_W'(ZONE_LIM);
      end else begin
         zones_new = csr_chan.zone_count;
      end
   end

   assign zone_sel  = k_ff[ZONE_IDX_W-1:0];
   assign scan_ch   = first_ff + off_ff;
   assign acq_ch    = first_ff + pos_ff;
   assign alu_value = (state_ff == ST_ACQ_UPD) ? occ_ff[acq_ch[CH_IDX_W-1:0]]
                                               : occ_ff[scan_ch[CH_IDX_W-1:0]];
   assign off_wrap  = (off_ff == span_ff - CHAN_W'(1));

   assign k_lt_rem    = (k_ff < rem_ff);
   assign k_min_rem   = k_lt_rem ? k_ff : rem_ff;
   assign master_prod = 8'(k_ff) * (8'(base_ff) + 8'd1);

   assign k_reduce  = ({1'b0, k_ff} >= zones_ff);
   assign ch_reduce = ({1'b0, ch_ff} >= (CHAN_W + 1)'(CHANNELS));

   zca_occ_alu u_alu (
      .value     (alu_value),
      .min_value (minv_ff),
      .flags     (alu_flags),
      .inc_value (alu_inc),
      .dec_value (alu_dec)
   );

   always_comb begin
      state_in       = state_ff;
      occ_in         = occ_ff;
      ss_in          = ss_ff;
      zones_in       = zones_ff;
      base_in        = base_ff;
      rem_in         = rem_ff;
      div_r_in       = div_r_ff;
      div_q_in       = div_q_ff;
      op_in          = op_ff;
      k_in           = k_ff;
      ch_in          = ch_ff;
      first_in       = first_ff;
      span_in        = span_ff;
      off_in         = off_ff;
      cnt_in         = cnt_ff;
      pos_in         = pos_ff;
      minv_in        = minv_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_channel_in = rsp_channel_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (csr_fire) begin
               zones_in = zones_new;
               for (int i = 0; i < CHANNELS; i++) begin
                  occ_in[i] = '0;
               end
               for (int i = 0; i < MAX_ZONES; i++) begin
                  ss_in[i] = '0;
               end
               div_r_in = (CHAN_W + 1)'(CHANNELS);
               div_q_in = '0;
               state_in = ST_DIV;
            end else if (req_fire) begin
               op_in    = req_chan.op;
               k_in     = req_chan.zone;
               ch_in    = req_chan.released_channel;
               state_in = ST_MOD;
            end
         end
         // CHANNELS / zones by repeated subtraction
         ST_DIV: begin
            if (div_r_ff >= {1'b0, zones_ff}) begin
               div_r_in = div_r_ff - {1'b0, zones_ff};
               div_q_in = div_q_ff + (CHAN_W + 1)'(1);
            end else begin
               base_in  = CHAN_W'(div_q_ff - (CHAN_W + 1)'(1));
               rem_in   = ZONE_W'(div_r_ff);
               state_in = ST_IDLE;
            end
         end
         // zone mod zones and channel mod CHANNELS, one subtraction each per cycle
         ST_MOD: begin
            if (k_reduce) begin
               k_in = ZONE_W'({1'b0, k_ff} - zones_ff);
            end
            if (ch_reduce) begin
               ch_in = CHAN_W'({1'b0, ch_ff} - (CHAN_W + 1)'(CHANNELS));
            end
            if (!k_reduce && !ch_reduce) begin
               state_in = ST_LAYOUT;
            end
         end
         ST_LAYOUT: begin
            first_in = CHAN_W'(master_prod + 8'(k_min_rem) + 8'd1);
            span_in  = base_ff + CHAN_W'(k_lt_rem);
            cnt_in   = '0;
            minv_in  = OCC_MAX;
            if (op_ff == OP_ACQUIRE) begin
               off_in   = ss_ff[zone_sel];
               pos_in   = ss_ff[zone_sel];
               state_in = ST_ACQ_SCAN;
            end else begin
               off_in   = '0;
               state_in = ST_REL_SCAN;
            end
         end
         ST_ACQ_SCAN: begin
            if (alu_flags.below_min) begin
               minv_in = alu_value;
               pos_in  = off_ff;
            end
            off_in = off_wrap ? '0 : off_ff + CHAN_W'(1);
            cnt_in = cnt_ff + CHAN_W'(1);
            if (cnt_ff == span_ff - CHAN_W'(1)) begin
               state_in = ST_ACQ_UPD;
            end
         end
         ST_ACQ_UPD: begin
            occ_in[acq_ch[CH_IDX_W-1:0]] = alu_inc;
            ss_in[zone_sel] = (pos_ff == span_ff - CHAN_W'(1)) ? '0 : pos_ff + CHAN_W'(1);
            ch_in    = acq_ch;
            state_in = ST_DONE;
         end
         ST_REL_SCAN: begin
            if (scan_ch == ch_ff || alu_flags.idle) begin
               occ_in[scan_ch[CH_IDX_W-1:0]] = alu_dec;
            end
            off_in = off_ff + CHAN_W'(1);
            if (off_wrap) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_channel_in = ch_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         zones_ff     <= ZCNT_W'(1);
         base_ff      <= CHAN_W'(CHANNELS - 1);
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            occ_ff[i] <= '0;
         end
         for (int i = 0; i < MAX_ZONES; i++) begin
            ss_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         zones_ff     <= zones_in;
         base_ff      <= base_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
         occ_ff       <= occ_in;
         ss_ff        <= ss_in;
      end
   end

   always_ff @(posedge clock) begin
      div_r_ff       <= div_r_in;
      div_q_ff       <= div_q_in;
      op_ff          <= op_in;
      k_ff           <= k_in;
      ch_ff          <= ch_in;
      first_ff       <= first_in;
      span_ff        <= span_in;
      off_ff         <= off_in;
      cnt_ff         <= cnt_in;
      pos_ff         <= pos_in;
      minv_ff        <= minv_in;
      rsp_channel_ff <= rsp_channel_in;
   end

`ifndef SYNTHESIS
   // zone 0 master is never touched
   a_master0_quiet: assert property (@(posedge clock) disable iff (reset)
      occ_ff[0] == 8'sd0)
      else $error("master channel 0 occupancy changed");

   a_zones_range: assert property (@(posedge clock) disable iff (reset)
      zones_ff >= ZCNT_W'(1) && zones_ff <= ZCNT_W'(ZONE_LIM))
      else $error("effective zone count out of range");

   a_pos_in_span: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACQ_UPD |-> pos_ff < span_ff)
      else $error("acquire position outside zone span");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response word raised outside done state");
`endif

endmodule
